@@ rtl/core/mmq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmq_pkg: shared types and constants of the min/max queue
// Request and status codes, channel payload types and the cell control group.
// ----------------------------------------------------------------------------
package mmq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        REQ_PUSH = 2'd0,
        REQ_POP  = 2'd1,
        REQ_PEEK = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_PUSH_FULL  = 2'd1,
        ST_POP_EMPTY  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] front_value;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic [4:0]         fill_count;
        logic               is_empty;
    } t_out_item;

    typedef struct packed {
        logic push;
        logic pop;
        logic tail;
    } t_cell_ctrl;

endpackage

@@ rtl/core/mmq_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmq_cell: one slot of the queue chain
// Holds an element and the minimum and maximum of it and all newer elements.
// Shifts from its rear neighbor on a pop, folds in the new value on a push.
// ----------------------------------------------------------------------------
module mmq_cell #(
    parameter int DATA_WIDTH = mmq_pkg::DATA_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  mmq_pkg::t_cell_ctrl          i_ctrl,
    input  logic signed [DATA_WIDTH-1:0] i_push_value,
    input  logic signed [DATA_WIDTH-1:0] i_nbr_value,
    input  logic signed [DATA_WIDTH-1:0] i_nbr_min,
    input  logic signed [DATA_WIDTH-1:0] i_nbr_max,
    output logic signed [DATA_WIDTH-1:0] o_value,
    output logic signed [DATA_WIDTH-1:0] o_min,
    output logic signed [DATA_WIDTH-1:0] o_max,
    output logic signed [DATA_WIDTH-1:0] o_next_value,
    output logic signed [DATA_WIDTH-1:0] o_next_min,
    output logic signed [DATA_WIDTH-1:0] o_next_max
);

    logic signed [DATA_WIDTH-1:0] r_value, r_min, r_max;
    logic signed [DATA_WIDTH-1:0] n_value, n_min, n_max;

    always_comb begin
        n_value = r_value;
        n_min   = r_min;
        n_max   = r_max;
        if (i_ctrl.pop) begin
            n_value = i_nbr_value;
            n_min   = i_nbr_min;
            n_max   = i_nbr_max;
        end else if (i_ctrl.push) begin
            if (i_ctrl.tail) begin
                n_value = i_push_value;
                n_min   = i_push_value;
                n_max   = i_push_value;
            end else begin
                if (i_push_value < r_min) n_min = i_push_value;
                if (i_push_value > r_max) n_max = i_push_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_min   <= n_min;
        r_max   <= n_max;
    end

    assign o_value      = r_value;
    assign o_min        = r_min;
    assign o_max        = r_max;
    assign o_next_value = n_value;
    assign o_next_min   = n_min;
    assign o_next_max   = n_max;

endmodule

@@ rtl/core/min_max_fifo_queue_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_max_fifo_queue_top: bounded FIFO reporting front, minimum and maximum
// Takes one push, pop or peek request per cycle while not stalled and
// returns one status item per request from an output register next cycle.
// ----------------------------------------------------------------------------
// The queue is a chain of DEPTH cells with the oldest element in cell 0. Each
// cell keeps the minimum and maximum of its element and all newer ones, so
// cell 0 always carries the answer for the whole queue. A pop shifts every
// cell one place toward the front, a push writes the cell at the fill count
// and folds its value into all cells ahead of it, all in the same cycle. A
// new request is taken every cycle while the result register is free or
// being drained. A push into a full queue returns status 1 and a pop from
// an empty one status 2, both leaving the contents unchanged; an empty
// queue reports zero for front, minimum and maximum.
// ----------------------------------------------------------------------------
module min_max_fifo_queue_top #(
    parameter int DEPTH      = mmq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = mmq_pkg::DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mmq_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mmq_pkg::t_out_item o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                         in_acc;
    logic                         is_full, is_empty_now;
    logic                         do_push, do_pop;
    logic [1:0]                   status;
    logic signed [DATA_WIDTH-1:0] push_value;

    logic [CW-1:0]                r_count, n_count;
    logic                         r_out_valid;
    mmq_pkg::t_out_item           r_out, n_out;

    mmq_pkg::t_cell_ctrl          ctrl     [DEPTH];
    logic signed [DATA_WIDTH-1:0] c_value  [DEPTH];
    logic signed [DATA_WIDTH-1:0] c_min    [DEPTH];
    logic signed [DATA_WIDTH-1:0] c_max    [DEPTH];
    logic signed [DATA_WIDTH-1:0] nx_value [DEPTH];
    logic signed [DATA_WIDTH-1:0] nx_min   [DEPTH];
    logic signed [DATA_WIDTH-1:0] nx_max   [DEPTH];

    assign o_in_stall   = r_out_valid && i_out_stall;
    assign in_acc       = i_in_valid && !o_in_stall;
    assign is_full      = (r_count == CW'(DEPTH));
    assign is_empty_now = (r_count == '0);
    assign push_value   = DATA_WIDTH'(i_in_data.push_value);

    always_comb begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        status  = mmq_pkg::ST_DONE;
        unique case (i_in_data.req_type)
            mmq_pkg::REQ_PUSH: begin
                if (is_full) status = mmq_pkg::ST_PUSH_FULL;
                else         do_push = in_acc;
            end
            mmq_pkg::REQ_POP: begin
                if (is_empty_now) status = mmq_pkg::ST_POP_EMPTY;
                else              do_pop = in_acc;
            end
            default: status = mmq_pkg::ST_DONE;
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (do_push)     n_count = r_count + CW'(1);
        else if (do_pop) n_count = r_count - CW'(1);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_WIDTH-1:0] nbr_value, nbr_min, nbr_max;

        if (g == DEPTH - 1) begin : g_last
            assign nbr_value = '0;
            assign nbr_min   = '0;
            assign nbr_max   = '0;
        end else begin : g_mid
            assign nbr_value = c_value[g+1];
            assign nbr_min   = c_min[g+1];
            assign nbr_max   = c_max[g+1];
        end

        assign ctrl[g].push = do_push;
        assign ctrl[g].pop  = do_pop;
        assign ctrl[g].tail = (r_count == CW'(g));

        mmq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl[g]),
            .i_push_value (push_value),
            .i_nbr_value  (nbr_value),
            .i_nbr_min    (nbr_min),
            .i_nbr_max    (nbr_max),
            .o_value      (c_value[g]),
            .o_min        (c_min[g]),
            .o_max        (c_max[g]),
            .o_next_value (nx_value[g]),
            .o_next_min   (nx_min[g]),
            .o_next_max   (nx_max[g])
        );
    end

    always_comb begin
        n_out.status      = status;
        n_out.fill_count  = 5'(n_count);
        n_out.is_empty    = (n_count == '0);
        n_out.front_value = '0;
        n_out.min_value   = '0;
        n_out.max_value   = '0;
        if (n_count != '0) begin
            n_out.front_value = 32'(nx_value[0]);
            n_out.min_value   = 32'(nx_min[0]);
            n_out.max_value   = 32'(nx_max[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_acc)            r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count beyond depth");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_count))
        else $error("fill count moved without a request");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out_valid)
        else $error("accepted request produced no result");

    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.req_type == mmq_pkg::REQ_POP && is_empty_now)
        |=> (o_out_data.status == mmq_pkg::ST_POP_EMPTY && o_out_data.is_empty))
        else $error("pop on empty not flagged");

endmodule
